// ----- src/dqi_pkg.sv -----
// Shared types and constants for the deque with indexed insert.
// No dependencies; every other file of the block imports this package.
package dqi_pkg;

   // Storage geometry.
   localparam int CAPACITY   = 16;
   localparam int DATA_WIDTH = 32;
   localparam int IDX_W      = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W      = $clog2(CAPACITY + 1);

   // Fixed widths of the channel fields.
   localparam int CMD_W   = 3;
   localparam int VALUE_W = 32;
   localparam int POS_W   = 4;
   localparam int STAT_W  = 2;
   localparam int COUNT_W = 5;

   typedef logic [DATA_WIDTH-1:0] data_type;
   typedef logic [IDX_W-1:0]      idx_type;
   typedef logic [CNT_W-1:0]      cnt_type;

   // Command codes carried by a request beat.
   typedef enum logic [CMD_W-1:0] {
      CMD_ADD_BACK   = 3'd0,
      CMD_ADD_FRONT  = 3'd1,
      CMD_TAKE_BACK  = 3'd2,
      CMD_TAKE_FRONT = 3'd3,
      CMD_INSERT     = 3'd4
   } cmd_type;

   // Status codes returned with every response beat.
   typedef enum logic [STAT_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_FULL  = 2'd2,
      ST_BAD   = 2'd3
   } status_type;

   // Broadcast from the controller to every cell of the chain.
   typedef struct packed {
      logic     load;        // the cell at load_idx takes the new word
      logic     shift_back;  // cells above load_idx take their front neighbor
      logic     shift_front; // every cell takes its back neighbor
      idx_type  load_idx;
      idx_type  tail_idx;    // index of the last occupied cell
      data_type wdata;
   } cell_ctrl_type;

   // Outcome of one command, from the controller to the response stage.
   typedef struct packed {
      status_type status;
      logic       take_back;
      logic       take_front;
      cnt_type    count;
   } cmd_result_type;

endpackage

// ----- src/dqi_req_if.sv -----
// Request channel of the deque: valid/ready handshake with a command beat.
// Depends on dqi_pkg for field widths.
interface dqi_req_if;
   import dqi_pkg::*;

   logic               valid;
   logic               ready;
   logic [CMD_W-1:0]   command;
   logic [VALUE_W-1:0] value;
   logic [POS_W-1:0]   position;

   modport source (output valid, output command, output value, output position,
                   input ready);
   modport sink   (input valid, input command, input value, input position,
                   output ready);
endinterface

// ----- src/dqi_rsp_if.sv -----
// Response channel of the deque: valid/ready handshake with a result beat.
// Depends on dqi_pkg for field widths.
interface dqi_rsp_if;
   import dqi_pkg::*;

   logic               valid;
   logic               ready;
   logic [VALUE_W-1:0] popped;
   logic [STAT_W-1:0]  status;
   logic [COUNT_W-1:0] count;

   modport source (output valid, output popped, output status, output count,
                   input ready);
   modport sink   (input valid, input popped, input status, input count,
                   output ready);
endinterface

// ----- src/dqi_cell.sv -----
// One storage cell of the deque chain: holds a word and trades with neighbors.
// Depends on dqi_pkg for the control struct and data types.
module dqi_cell (
   input  logic                   clock,
   input  logic                   enable,
   input  dqi_pkg::idx_type       idx,
   input  dqi_pkg::cell_ctrl_type ctrl,
   input  dqi_pkg::data_type      front_data,
   input  dqi_pkg::data_type      back_data,
   output dqi_pkg::data_type      data,
   output dqi_pkg::data_type      tail_data
);
   import dqi_pkg::*;

   data_type data_ff;
   data_type data_in;

   // Pick the next content: new word, front neighbor, back neighbor or hold.
   always_comb begin
      data_in = data_ff;
      if (ctrl.load && (idx == ctrl.load_idx)) begin
         data_in = ctrl.wdata;
      end else if (ctrl.shift_back && (idx > ctrl.load_idx)) begin
         data_in = front_data;
      end else if (ctrl.shift_front) begin
         data_in = back_data;
      end
   end

   // Storage needs no reset; only occupied cells are ever read.
   always_ff @(posedge clock) begin
      if (enable) begin
         data_ff <= data_in;
      end
   end

   assign data      = data_ff;
   assign tail_data = (idx == ctrl.tail_idx) ? data_ff : '0;

endmodule

// ----- src/dqi_ctrl.sv -----
// Command decoder and entry counter of the deque.
// Depends on dqi_pkg for command, status and control types.
module dqi_ctrl (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          fire,
   input  logic [dqi_pkg::CMD_W-1:0]     command,
   input  logic [dqi_pkg::VALUE_W-1:0]   value,
   input  logic [dqi_pkg::POS_W-1:0]     position,
   output dqi_pkg::cell_ctrl_type        ctrl,
   output dqi_pkg::cmd_result_type       result
);
   import dqi_pkg::*;

   cnt_type count_ff;
   cnt_type count_in;
   logic    full;
   logic    empty;
   logic    pos_bad;

   assign full    = (count_ff == cnt_type'(CAPACITY));
   assign empty   = (count_ff == '0);
   assign pos_bad = (32'(position) >= 32'(count_ff));

   // Decode the command into a cell broadcast and a result.
   always_comb begin
      ctrl.load         = 1'b0;
      ctrl.shift_back   = 1'b0;
      ctrl.shift_front  = 1'b0;
      ctrl.load_idx     = '0;
      ctrl.tail_idx     = idx_type'(count_ff - cnt_type'(1));
      ctrl.wdata        = data_type'(value);
      result.status     = ST_OK;
      result.take_back  = 1'b0;
      result.take_front = 1'b0;
      count_in          = count_ff;
      unique case (command)
         CMD_ADD_BACK: begin
            if (full) begin
               result.status = ST_FULL;
            end else begin
               ctrl.load     = fire;
               ctrl.load_idx = idx_type'(count_ff);
               count_in      = count_ff + cnt_type'(1);
            end
         end
         CMD_ADD_FRONT: begin
            if (full) begin
               result.status = ST_FULL;
            end else begin
               ctrl.load       = fire;
               ctrl.shift_back = fire;
               count_in        = count_ff + cnt_type'(1);
            end
         end
         CMD_TAKE_BACK: begin
            if (empty) begin
               result.status = ST_EMPTY;
            end else begin
               result.take_back = 1'b1;
               count_in         = count_ff - cnt_type'(1);
            end
         end
         CMD_TAKE_FRONT: begin
            if (empty) begin
               result.status = ST_EMPTY;
            end else begin
               result.take_front = 1'b1;
               ctrl.shift_front  = fire;
               count_in          = count_ff - cnt_type'(1);
            end
         end
         CMD_INSERT: begin
            if (full) begin
               result.status = ST_FULL;
            end else if (pos_bad) begin
               result.status = ST_BAD;
            end else begin
               ctrl.load       = fire;
               ctrl.shift_back = fire;
               ctrl.load_idx   = idx_type'(position);
               count_in        = count_ff + cnt_type'(1);
            end
         end
         default: begin
            result.status = ST_BAD;
         end
      endcase
      result.count = count_in;
   end

   // Entry counter.
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (fire) begin
         count_ff <= count_in;
      end
   end

endmodule

// ----- src/double_ended_queue_with_insert.sv -----
// Top level of the deque with indexed insert: controller, cell chain, output stage.
// Depends on dqi_pkg, dqi_req_if, dqi_rsp_if, dqi_ctrl and dqi_cell.
//
// A bounded deque of up to 16 words held in a chain of cells, one word per
// cell, slot 0 at the front. Every request beat (push back, push front, pop
// back, pop front, insert at index) completes in the cycle it is accepted:
// all cells shift or load in parallel, so one command per clock is sustained
// while responses are drained. Each response beat (popped word, status, new
// count) is registered and shows in the next cycle. A new request is taken
// whenever the response register is empty or is being drained in the same
// cycle. After reset the deque is empty and ready at once; there is no
// clearing pass, the cells are simply never read beyond the count.
module double_ended_queue_with_insert (
   input logic       clock,
   input logic       reset,
   dqi_req_if.sink   req,
   dqi_rsp_if.source rsp
);
   import dqi_pkg::*;

   cell_ctrl_type  ctrl;
   cell_ctrl_type  cell_ctrl;
   cmd_result_type result;
   logic           fire;
   data_type       cell_data [CAPACITY];
   data_type       tail_data [CAPACITY];
   data_type       tail_word;

   logic                 rsp_valid_ff;
   logic [VALUE_W-1:0]   rsp_popped_ff;
   logic [VALUE_W-1:0]   rsp_popped_in;
   status_type           rsp_status_ff;
   logic [COUNT_W-1:0]   rsp_count_ff;

   // Accept while the response register is free or drains this cycle.
   assign req.ready = !rsp_valid_ff || rsp.ready;
   assign fire      = req.valid && req.ready;

   dqi_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .fire     (fire),
      .command  (req.command),
      .value    (req.value),
      .position (req.position),
      .ctrl     (ctrl),
      .result   (result)
   );

   assign cell_ctrl = ctrl;

   // Chain of cells; the ends see zero from the missing neighbor.
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      data_type front_nb;
      data_type back_nb;
      if (i == 0) begin : g_first
         assign front_nb = '0;
      end else begin : g_mid_front
         assign front_nb = cell_data[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign back_nb = '0;
      end else begin : g_mid_back
         assign back_nb = cell_data[i+1];
      end
      dqi_cell u_cell (
         .clock      (clock),
         .enable     (fire),
         .idx        (idx_type'(i)),
         .ctrl       (cell_ctrl),
         .front_data (front_nb),
         .back_data  (back_nb),
         .data       (cell_data[i]),
         .tail_data  (tail_data[i])
      );
   end

   // Only the cell at tail_idx, the last occupied one, can drive a nonzero tail word.
   always_comb begin
      tail_word = '0;
      for (int i = 0; i < CAPACITY; i++) begin
         tail_word = tail_word | tail_data[i];
      end
   end

   // Popped word for the response beat.
   always_comb begin
      rsp_popped_in = '0;
      if (result.take_back) begin
         rsp_popped_in = VALUE_W'(tail_word);
      end else if (result.take_front) begin
         rsp_popped_in = VALUE_W'(cell_data[0]);
      end
   end

   // Response valid flag.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // Response payload.
   always_ff @(posedge clock) begin
      if (fire) begin
         rsp_popped_ff <= rsp_popped_in;
         rsp_status_ff <= result.status;
         rsp_count_ff  <= COUNT_W'(result.count);
      end
   end

   assign rsp.valid  = rsp_valid_ff;
   assign rsp.popped = rsp_popped_ff;
   assign rsp.status = rsp_status_ff;
   assign rsp.count  = rsp_count_ff;

endmodule
